### sv/sensor_frame_crc_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// Sensor frame CRC checker: assertion macros
// Shared concurrent-check helpers for the frame checker RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFCC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/sfcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker package
// Frame geometry, CRC-8 constants, status codes and item types.
// ----------------------------------------------------------------------------
package sfcc_pkg;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int POS_W  = 4;
   localparam int STAT_W = 2;

   localparam int FRAME_BYTES = 9;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   // CRC-8, poly 0x31, init 0xFF, no reflection, no final xor
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_RX_ERR     = 2'd1,
      STATUS_CRC_ERR    = 2'd2,
      STATUS_ZERO_SCALE = 2'd3
   } status_type;

   typedef struct packed {
      logic        [BYTE_W-1:0] rx_byte;
      logic                     bus_error;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pressure_ticks;
      logic signed [WORD_W-1:0] temp_ticks;
      logic signed [WORD_W-1:0] scale_word;
      logic        [STAT_W-1:0] status_code;
      logic                     frame_valid;
   } rsp_item_type;

   // Frame engine to top: result of consuming one byte
   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } frame_result_type;

endpackage

### sv/sfcc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker: request channel
// Valid/ready channel carrying one received frame byte per transfer.
// ----------------------------------------------------------------------------
interface sfcc_req_if;
   logic                             valid;
   logic                             ready;
   logic [sfcc_pkg::BYTE_W-1:0]      rx_byte;
   logic                             bus_error;

   modport source (output valid, output rx_byte, output bus_error, input ready);
   modport sink   (input valid, input rx_byte, input bus_error, output ready);
endinterface

### sv/sfcc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker: response channel
// Valid/ready channel carrying one checked frame result per transfer.
// ----------------------------------------------------------------------------
interface sfcc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [sfcc_pkg::WORD_W-1:0] pressure_ticks;
   logic signed [sfcc_pkg::WORD_W-1:0] temp_ticks;
   logic signed [sfcc_pkg::WORD_W-1:0] scale_word;
   logic        [sfcc_pkg::STAT_W-1:0] status_code;
   logic                               frame_valid;

   modport source (output valid, output pressure_ticks, output temp_ticks,
                   output scale_word, output status_code, output frame_valid,
                   input ready);
   modport sink   (input valid, input pressure_ticks, input temp_ticks,
                   input scale_word, input status_code, input frame_valid,
                   output ready);
endinterface

### sv/sfcc_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker: CRC-8 byte update
// One byte through the poly 0x31 shift register, unrolled over eight bits.
// ----------------------------------------------------------------------------
module sfcc_crc8 (
   input  logic [sfcc_pkg::BYTE_W-1:0] crc_in,
   input  logic [sfcc_pkg::BYTE_W-1:0] data_in,
   output logic [sfcc_pkg::BYTE_W-1:0] crc_out
);

   always_comb begin
      logic [sfcc_pkg::BYTE_W-1:0] c;
      c = crc_in ^ data_in;
      for (int i = 0; i < sfcc_pkg::BYTE_W; i++) begin
         if (c[sfcc_pkg::BYTE_W-1]) begin
            c = {c[sfcc_pkg::BYTE_W-2:0], 1'b0} ^ sfcc_pkg::CRC_POLY;
         end else begin
            c = {c[sfcc_pkg::BYTE_W-2:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule

### sv/sfcc_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker: frame engine
// Tracks byte position, running CRC and assembled words; builds the result.
// ----------------------------------------------------------------------------
module sfcc_frame (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         consume,
   input  sfcc_pkg::req_item_type       item,
   output sfcc_pkg::frame_result_type   result
);

   typedef enum logic [1:0] {
      SLOT_HIGH  = 2'd0,
      SLOT_LOW   = 2'd1,
      SLOT_CHECK = 2'd2
   } slot_type;

   logic [sfcc_pkg::POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [sfcc_pkg::BYTE_W-1:0] crc_ff, crc_in;
   logic                        failed_ff, failed_in;
   logic [sfcc_pkg::BYTE_W-1:0] high_ff, high_in;
   logic [sfcc_pkg::WORD_W-1:0] press_ff, press_in;
   logic [sfcc_pkg::WORD_W-1:0] temp_ff, temp_in;
   logic [sfcc_pkg::WORD_W-1:0] scale_ff, scale_in;

   slot_type                    slot;
   logic [sfcc_pkg::BYTE_W-1:0] crc_seed, crc_next;
   logic [sfcc_pkg::WORD_W-1:0] word;
   logic                        last, fail;

   assign pos_eff = (pos_ff > sfcc_pkg::LAST_POS) ? sfcc_pkg::LAST_POS : pos_ff;

   always_comb begin
      case (pos_eff)
         4'd0, 4'd3, 4'd6: slot = SLOT_HIGH;
         4'd1, 4'd4, 4'd7: slot = SLOT_LOW;
         default:          slot = SLOT_CHECK;
      endcase
   end

   assign crc_seed = (slot == SLOT_HIGH) ? sfcc_pkg::CRC_INIT : crc_ff;
   assign word     = {high_ff, item.rx_byte};
   assign last     = (pos_eff == sfcc_pkg::LAST_POS);
   assign fail     = failed_ff | ((slot == SLOT_CHECK) && (crc_ff != item.rx_byte));

   sfcc_crc8 u_crc (
      .crc_in  (crc_seed),
      .data_in (item.rx_byte),
      .crc_out (crc_next)
   );

   // state update
   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      failed_in = failed_ff;
      high_in   = high_ff;
      press_in  = press_ff;
      temp_in   = temp_ff;
      scale_in  = scale_ff;
      if (consume) begin
         if (item.bus_error || last) begin
            pos_in    = '0;
            crc_in    = sfcc_pkg::CRC_INIT;
            failed_in = 1'b0;
         end else begin
            pos_in = pos_eff + 1'b1;
            case (slot)
               SLOT_HIGH: begin
                  high_in = item.rx_byte;
                  crc_in  = crc_next;
               end
               SLOT_LOW: begin
                  crc_in = crc_next;
                  if (pos_eff == 4'd1) begin
                     press_in = word;
                  end else if (pos_eff == 4'd4) begin
                     temp_in = word;
                  end else begin
                     scale_in = word;
                  end
               end
               default: begin
                  failed_in = fail;
                  crc_in    = sfcc_pkg::CRC_INIT;
               end
            endcase
         end
      end
   end

   // result build
   always_comb begin
      result.emit = item.bus_error | last;
      result.item.pressure_ticks = press_ff;
      result.item.temp_ticks     = temp_ff;
      result.item.scale_word     = scale_ff;
      if (item.bus_error) begin
         result.item.pressure_ticks = '0;
         result.item.temp_ticks     = '0;
         result.item.scale_word     = '0;
         result.item.status_code    = sfcc_pkg::STATUS_RX_ERR;
      end else if (fail) begin
         result.item.pressure_ticks = '0;
         result.item.temp_ticks     = '0;
         result.item.scale_word     = '0;
         result.item.status_code    = sfcc_pkg::STATUS_CRC_ERR;
      end else if (scale_ff == '0) begin
         result.item.status_code    = sfcc_pkg::STATUS_ZERO_SCALE;
      end else begin
         result.item.status_code    = sfcc_pkg::STATUS_OK;
      end
      result.item.frame_valid = (result.item.status_code == sfcc_pkg::STATUS_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= sfcc_pkg::CRC_INIT;
         failed_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         failed_ff <= failed_in;
      end
   end

   // word holds are always written within a frame before they are read
   always_ff @(posedge clock) begin
      high_ff  <= high_in;
      press_ff <= press_in;
      temp_ff  <= temp_in;
      scale_ff <= scale_in;
   end

endmodule

### sv/sensor_frame_crc_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC checker unit
// Checks nine-byte, three-word sensor frames with a CRC-8 on every word.
// ----------------------------------------------------------------------------
// Feed received bytes on req_if, one per transfer, in wire order. Each frame
// is three words (pressure, temperature, scale), each two big-endian bytes
// followed by a CRC-8 byte (poly 0x31, init 0xFF). One result comes out on
// rsp_if after the ninth byte, or right away for a byte flagged bus_error,
// which also aborts the frame. Words read zero on a bus or CRC error; a zero
// scale is flagged but the words still come through. The block takes one
// byte per clock while nothing is held: bytes land in an input register,
// and the frame engine (one unrolled CRC byte step plus compares) writes
// the result register that drives rsp valid when a frame ends. A byte
// that ends a frame (the ninth, or one flagged bus_error) waits in the input
// register only while the result register is full and not being taken;
// other bytes never stall on their own.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_checker_unit_defines.svh"

module sensor_frame_crc_checker_unit (
   input  logic        clock,
   input  logic        reset,
   sfcc_req_if.sink    req_if,
   sfcc_rsp_if.source  rsp_if
);

   // input register
   logic                       s1_valid_ff, s1_valid_in;
   sfcc_pkg::req_item_type     s1_item_ff, s1_item_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   sfcc_pkg::rsp_item_type     out_item_ff, out_item_in;

   sfcc_pkg::frame_result_type frame_res;
   logic                       s1_advance;
   logic                       out_free;

   // result slot is usable if empty or drained this cycle
   assign out_free   = !out_valid_ff || rsp_if.ready;
   // bytes that finish nothing always advance; frame ends need a free slot
   assign s1_advance = s1_valid_ff && (!frame_res.emit || out_free);

   assign req_if.ready = !s1_valid_ff || s1_advance;

   sfcc_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .consume (s1_advance),
      .item    (s1_item_ff),
      .result  (frame_res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_if.valid && req_if.ready) begin
         s1_valid_in         = 1'b1;
         s1_item_in.rx_byte   = req_if.rx_byte;
         s1_item_in.bus_error = req_if.bus_error;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (s1_advance && frame_res.emit) begin
         out_valid_in = 1'b1;
         out_item_in  = frame_res.item;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.pressure_ticks = out_item_ff.pressure_ticks;
   assign rsp_if.temp_ticks     = out_item_ff.temp_ticks;
   assign rsp_if.scale_word     = out_item_ff.scale_word;
   assign rsp_if.status_code    = out_item_ff.status_code;
   assign rsp_if.frame_valid    = out_item_ff.frame_valid;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // a bus-error byte taken by the engine shows up as a receive error next
   `SFCC_ASSERT_NEXT(a_bus_err_reported, clock, reset,
      s1_advance && s1_item_ff.bus_error,
      out_valid_ff && (out_item_ff.status_code == sfcc_pkg::STATUS_RX_ERR),
      "bus error transfer not reported as receive error")
   // CRC failures never leak data words
   `SFCC_ASSERT_NOW(a_crc_err_zero, clock, reset,
      rsp_if.valid && (rsp_if.status_code == sfcc_pkg::STATUS_CRC_ERR),
      (rsp_if.pressure_ticks == '0) && (rsp_if.temp_ticks == '0)
         && (rsp_if.scale_word == '0),
      "CRC mismatch result carries nonzero words")
   // backpressure on req only comes from a held byte in the input register
   `SFCC_ASSERT_NOW(a_stall_source, clock, reset,
      !req_if.ready,
      s1_valid_ff && frame_res.emit && out_valid_ff && !rsp_if.ready,
      "request stalled without a blocked frame end")
   // valid flag tracks status
   `SFCC_ASSERT_NOW(a_valid_flag, clock, reset,
      rsp_if.valid,
      rsp_if.frame_valid == (rsp_if.status_code == sfcc_pkg::STATUS_OK),
      "frame_valid disagrees with status_code")

endmodule
